// ===== hw/rtl/fixed_block_free_list_unit_macros.svh =====
// Assertion helpers for the block allocator. The macros expand to nothing in synthesis.
// Each one expects clk_i and rst_ni to exist in the scope where it is used.
`ifndef FIXED_BLOCK_FREE_LIST_UNIT_MACROS_SVH
`define FIXED_BLOCK_FREE_LIST_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// The property must hold on every clock edge outside reset.
`define FBFL_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// When the antecedent is true, the consequent must hold on the next edge.
`define FBFL_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`else

`define FBFL_ASSERT(name, prop, msg)
`define FBFL_ASSERT_NEXT(name, ante, cons, msg)

`endif

`endif

// ===== hw/rtl/fbfl_pkg.sv =====
package fbfl_pkg;

  localparam int unsigned BUCKET_BYTES = 8192;
  localparam int unsigned MAX_BLOCKS   = 4096;
  localparam int unsigned MIN_BLOCK    = 2;
  localparam int unsigned CFG_RESET    = 2;

  // field widths
  localparam int unsigned CFG_W  = 14;
  localparam int unsigned OFF_W  = 13;
  localparam int unsigned IDX_W  = 12;
  localparam int unsigned CNT_W  = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned ADDR_W = $clog2(MAX_BLOCKS);
  localparam int unsigned DIV_W  = $clog2(BUCKET_BYTES) + 1;
  localparam int unsigned STEP_W = $clog2(DIV_W);

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2,
    ST_ALIGN = 2'd3
  } fbfl_status_e;

  // controller -> datapath
  typedef struct packed {
    logic take;         // input beat accepted
    logic clr_step;     // write one link entry of the init sweep
    logic div_start;
    logic div_bucket;   // divide the bucket size instead of the offset
    logic count_load;   // load block count, reset head and used count
    logic alloc_issue;  // read link at head, multiply head by size
    logic alloc_done;
    logic alloc_fail;
    logic free_done;
  } fbfl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic full;
    logic clr_last;
    logic div_done;
    logic out_free;
  } fbfl_sts_t;

endpackage

// ===== hw/rtl/fbfl_div.sv =====
// Restoring divider, one quotient bit per cycle.
module fbfl_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [fbfl_pkg::DIV_W-1:0]   dividend_i,
  input  logic [fbfl_pkg::CFG_W-1:0]   divisor_i,
  output logic                         done_o,
  output logic [fbfl_pkg::DIV_W-1:0]   quot_o,
  output logic [fbfl_pkg::CFG_W-1:0]   rem_o
);

  logic [fbfl_pkg::DIV_W-1:0]  quo_q;
  logic [fbfl_pkg::CFG_W-1:0]  rem_q;
  logic [fbfl_pkg::CFG_W-1:0]  dvs_q;
  logic [fbfl_pkg::STEP_W-1:0] step_q;
  logic                        busy_q;
  logic                        done_q;

  logic [fbfl_pkg::CFG_W:0]    shifted;
  logic [fbfl_pkg::CFG_W+1:0]  diff;
  logic                        ge;

  assign shifted = {rem_q, quo_q[fbfl_pkg::DIV_W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, dvs_q};
  assign ge      = !diff[fbfl_pkg::CFG_W+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      step_q <= '0;
    end else if (busy_q) begin
      step_q <= step_q + fbfl_pkg::STEP_W'(1);
      if (step_q == fbfl_pkg::STEP_W'(fbfl_pkg::DIV_W - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[fbfl_pkg::DIV_W-2:0], ge};
      rem_q <= ge ? diff[fbfl_pkg::CFG_W-1:0] : shifted[fbfl_pkg::CFG_W-1:0];
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;
  assign rem_o  = rem_q;

endmodule

// ===== hw/rtl/fbfl_dp.sv =====
`include "fixed_block_free_list_unit_macros.svh"

// Datapath: link table, list head, counters, multiplier, divider, output register.
module fbfl_dp (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [fbfl_pkg::CFG_W-1:0]  cfg_wdata_i,
  input  logic [fbfl_pkg::OFF_W-1:0]  offset_i,
  input  logic                        out_ready_i,
  input  fbfl_pkg::fbfl_cmd_t         cmd_i,
  output fbfl_pkg::fbfl_sts_t         sts_o,
  output logic                        out_valid_o,
  output logic [1:0]                  status_o,
  output logic [fbfl_pkg::OFF_W-1:0]  block_offset_o,
  output logic [fbfl_pkg::IDX_W-1:0]  block_index_o,
  output logic [fbfl_pkg::CNT_W-1:0]  used_count_o,
  output logic                        pool_empty_o,
  output logic                        is_full_o
);

  localparam int unsigned PROD_W = fbfl_pkg::ADDR_W + fbfl_pkg::CFG_W;

  // control state
  logic [fbfl_pkg::CFG_W-1:0]  bs_q;
  logic [fbfl_pkg::ADDR_W-1:0] clr_q, clr_d;
  logic [fbfl_pkg::CNT_W-1:0]  count_q, count_d;
  logic [fbfl_pkg::CNT_W-1:0]  head_q, head_d;
  logic [fbfl_pkg::CNT_W-1:0]  used_q, used_d;
  logic                        out_valid_q, out_valid_d;

  // payload
  logic [fbfl_pkg::OFF_W-1:0]  offset_q;
  logic [fbfl_pkg::CNT_W-1:0]  link_rd_q;
  logic [fbfl_pkg::OFF_W-1:0]  prod_q;
  logic [fbfl_pkg::IDX_W-1:0]  aidx_q;
  fbfl_pkg::fbfl_status_e      status_q;
  logic [fbfl_pkg::OFF_W-1:0]  boff_q;
  logic [fbfl_pkg::IDX_W-1:0]  bidx_q;
  logic [fbfl_pkg::CNT_W-1:0]  rused_q;
  logic                        empty_q;
  logic                        fullf_q;

  logic [fbfl_pkg::CNT_W-1:0]  link_mem [fbfl_pkg::MAX_BLOCKS];

  logic [fbfl_pkg::CFG_W-1:0]  bs_eff;
  logic [PROD_W-1:0]           prod;
  logic [fbfl_pkg::DIV_W-1:0]  div_dividend;
  logic                        div_done;
  logic [fbfl_pkg::DIV_W-1:0]  quot;
  logic [fbfl_pkg::CFG_W-1:0]  rem;
  logic [fbfl_pkg::DIV_W-1:0]  quot_cap;
  logic                        off_oob;

  fbfl_pkg::fbfl_status_e      res_status;
  logic [fbfl_pkg::OFF_W-1:0]  res_boff;
  logic [fbfl_pkg::IDX_W-1:0]  res_bidx;
  logic [fbfl_pkg::CNT_W-1:0]  res_used;
  logic                        res_load;
  logic                        free_ok;

  logic                        mem_we;
  logic [fbfl_pkg::ADDR_W-1:0] mem_wa;
  logic [fbfl_pkg::CNT_W-1:0]  mem_wd;

  assign bs_eff = (bs_q < fbfl_pkg::CFG_W'(fbfl_pkg::MIN_BLOCK))
                ? fbfl_pkg::CFG_W'(fbfl_pkg::MIN_BLOCK) : bs_q;

  assign prod = PROD_W'(head_q[fbfl_pkg::ADDR_W-1:0]) * PROD_W'(bs_eff);

  assign div_dividend = cmd_i.div_bucket ? fbfl_pkg::DIV_W'(fbfl_pkg::BUCKET_BYTES)
                                         : fbfl_pkg::DIV_W'(offset_q);

  fbfl_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_dividend),
    .divisor_i  (bs_eff),
    .done_o     (div_done),
    .quot_o     (quot),
    .rem_o      (rem)
  );

  assign quot_cap = (quot > fbfl_pkg::DIV_W'(fbfl_pkg::MAX_BLOCKS))
                  ? fbfl_pkg::DIV_W'(fbfl_pkg::MAX_BLOCKS) : quot;
  assign off_oob  = fbfl_pkg::DIV_W'(offset_q) >= fbfl_pkg::DIV_W'(fbfl_pkg::BUCKET_BYTES);

  // result of the item finishing this cycle
  always_comb begin
    res_status = fbfl_pkg::ST_OK;
    res_boff   = '0;
    res_bidx   = '0;
    res_used   = used_q;
    if (cmd_i.alloc_done) begin
      res_boff = prod_q;
      res_bidx = aidx_q;
      res_used = used_q + fbfl_pkg::CNT_W'(1);
    end else if (cmd_i.alloc_fail) begin
      res_status = fbfl_pkg::ST_FULL;
    end else begin
      priority if (off_oob) begin
        res_status = fbfl_pkg::ST_RANGE;
      end else if (rem != '0) begin
        res_status = fbfl_pkg::ST_ALIGN;
      end else if (quot >= fbfl_pkg::DIV_W'(count_q)) begin
        res_status = fbfl_pkg::ST_RANGE;
      end else begin
        res_boff = offset_q;
        res_bidx = quot[fbfl_pkg::IDX_W-1:0];
        res_used = (used_q != '0) ? used_q - fbfl_pkg::CNT_W'(1) : used_q;
      end
    end
  end

  assign res_load = cmd_i.alloc_done | cmd_i.alloc_fail | cmd_i.free_done;
  assign free_ok  = cmd_i.free_done && (res_status == fbfl_pkg::ST_OK);

  // link table write: init sweep or push
  assign mem_we = cmd_i.clr_step | free_ok;
  assign mem_wa = cmd_i.clr_step ? clr_q : quot[fbfl_pkg::ADDR_W-1:0];
  assign mem_wd = cmd_i.clr_step ? fbfl_pkg::CNT_W'(clr_q) + fbfl_pkg::CNT_W'(1) : head_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      link_mem[mem_wa] <= mem_wd;
    end
    if (cmd_i.alloc_issue) begin
      link_rd_q <= link_mem[head_q[fbfl_pkg::ADDR_W-1:0]];
    end
  end

  always_comb begin
    clr_d = clr_q;
    if (cfg_we_i) begin
      clr_d = '0;
    end else if (cmd_i.clr_step) begin
      clr_d = clr_q + fbfl_pkg::ADDR_W'(1);
    end
  end

  always_comb begin
    count_d = count_q;
    head_d  = head_q;
    used_d  = used_q;
    if (cmd_i.count_load) begin
      count_d = quot_cap[fbfl_pkg::CNT_W-1:0];
      head_d  = '0;
      used_d  = '0;
    end else if (cmd_i.alloc_done) begin
      head_d = link_rd_q;
      used_d = res_used;
    end else if (free_ok) begin
      head_d = quot[fbfl_pkg::CNT_W-1:0];
      used_d = res_used;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bs_q        <= fbfl_pkg::CFG_W'(fbfl_pkg::CFG_RESET);
      clr_q       <= '0;
      count_q     <= '0;
      head_q      <= '0;
      used_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        bs_q <= cfg_wdata_i;
      end
      clr_q       <= clr_d;
      count_q     <= count_d;
      head_q      <= head_d;
      used_q      <= used_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      offset_q <= offset_i;
    end
    if (cmd_i.alloc_issue) begin
      prod_q <= prod[fbfl_pkg::OFF_W-1:0];
      aidx_q <= head_q[fbfl_pkg::IDX_W-1:0];
    end
    if (res_load) begin
      status_q <= res_status;
      boff_q   <= res_boff;
      bidx_q   <= res_bidx;
      rused_q  <= res_used;
      empty_q  <= (res_used == '0);
      fullf_q  <= (res_used == count_q);
    end
  end

  assign sts_o.full     = (used_q >= count_q) || (head_q >= count_q);
  assign sts_o.clr_last = (clr_q == fbfl_pkg::ADDR_W'(fbfl_pkg::MAX_BLOCKS - 1));
  assign sts_o.div_done = div_done;
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign block_offset_o = boff_q;
  assign block_index_o  = bidx_q;
  assign used_count_o   = rused_q;
  assign pool_empty_o   = empty_q;
  assign is_full_o      = fullf_q;

  `FBFL_ASSERT(a_used_le_count, used_q <= count_q, "used count exceeds block count")
  `FBFL_ASSERT(a_count_cap, count_q <= fbfl_pkg::CNT_W'(fbfl_pkg::MAX_BLOCKS), "count over cap")
  `FBFL_ASSERT(a_no_overwrite, res_load |-> (!out_valid_q || out_ready_i), "result overwrites beat")
  `FBFL_ASSERT_NEXT(a_alloc_inc, cmd_i.alloc_done, used_q == $past(res_used), "alloc count stuck")

endmodule

// ===== hw/rtl/fbfl_ctrl.sv =====
// Sequencer for init sweep, block count division, allocate and free.
module fbfl_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic                 in_valid_i,
  input  logic                 op_i,
  input  fbfl_pkg::fbfl_sts_t  sts_i,
  output fbfl_pkg::fbfl_cmd_t  cmd_o,
  output logic                 in_ready_o
);

  typedef enum logic [7:0] {
    S_INIT_CLR  = 8'b0000_0001,
    S_INIT_DIV  = 8'b0000_0010,
    S_INIT_WAIT = 8'b0000_0100,
    S_IDLE      = 8'b0000_1000,
    S_ALLOC     = 8'b0001_0000,
    S_ALLOC_WB  = 8'b0010_0000,
    S_FREE      = 8'b0100_0000,
    S_FREE_WAIT = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;
  logic   ready;

  assign ready      = (state_q == S_IDLE) && !cfg_we_i;
  assign in_ready_o = ready;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_INIT_CLR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) begin
          state_d = S_INIT_DIV;
        end
      end
      S_INIT_DIV: begin
        cmd_o.div_start  = 1'b1;
        cmd_o.div_bucket = 1'b1;
        state_d          = S_INIT_WAIT;
      end
      S_INIT_WAIT: begin
        if (sts_i.div_done) begin
          cmd_o.count_load = 1'b1;
          state_d          = S_IDLE;
        end
      end
      S_IDLE: begin
        if (ready && in_valid_i) begin
          cmd_o.take = 1'b1;
          state_d    = (op_i == fbfl_pkg::OP_FREE) ? S_FREE : S_ALLOC;
        end
      end
      S_ALLOC: begin
        if (sts_i.full) begin
          if (sts_i.out_free) begin
            cmd_o.alloc_fail = 1'b1;
            state_d          = S_IDLE;
          end
        end else begin
          cmd_o.alloc_issue = 1'b1;
          state_d           = S_ALLOC_WB;
        end
      end
      S_ALLOC_WB: begin
        if (sts_i.out_free) begin
          cmd_o.alloc_done = 1'b1;
          state_d          = S_IDLE;
        end
      end
      S_FREE: begin
        cmd_o.div_start = 1'b1;
        state_d         = S_FREE_WAIT;
      end
      S_FREE_WAIT: begin
        if (sts_i.div_done && sts_i.out_free) begin
          cmd_o.free_done = 1'b1;
          state_d         = S_IDLE;
        end
      end
      default: begin
        state_d = S_INIT_CLR;
      end
    endcase
    // a block size write rebuilds the list from scratch
    if (cfg_we_i) begin
      cmd_o   = '0;
      state_d = S_INIT_CLR;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT_CLR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== hw/rtl/fixed_block_free_list_unit.sv =====
// Fixed-size block allocator over an 8192-byte bucket. The block size (clamped to at least 2)
// splits the bucket into up to 4096 blocks kept on a LIFO free list, block i initially
// linked to i+1. An allocate beat (op 0) pops the list head and returns its byte offset and
// index; a free beat (op 1) turns the offset into a block index and pushes it back. Errors
// (full, out of range, misaligned) return a status code with zero offset and index and leave
// the list alone; double frees are not caught. Every result beat also carries the used count
// and empty/full flags after the item. After reset, and after every block size write, the
// unit sweeps the 4096-entry link table one entry per cycle and then divides the bucket size
// by the block size, with in_ready_o low throughout; configuration writes are taken at
// any time and restart that sequence. One item is in flight at a time: an allocate reads
// the link table and multiplies, then updates the head and registers the result, or
// registers a full status without the read when the list is full; a free runs the 14-step
// restoring divider that splits the offset by the block size. The result sits in an output
// register, so the next beat is accepted while it waits; a result that cannot leave stalls
// the following item at its last step.
module fixed_block_free_list_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [fbfl_pkg::CFG_W-1:0]  cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        op_i,
  input  logic [fbfl_pkg::OFF_W-1:0]  offset_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [1:0]                  status_o,
  output logic [fbfl_pkg::OFF_W-1:0]  block_offset_o,
  output logic [fbfl_pkg::IDX_W-1:0]  block_index_o,
  output logic [fbfl_pkg::CNT_W-1:0]  used_count_o,
  output logic                        pool_empty_o,
  output logic                        is_full_o
);

  fbfl_pkg::fbfl_cmd_t cmd;
  fbfl_pkg::fbfl_sts_t sts;

  // sequencer: owns the input handshake and issues one command set per cycle
  fbfl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .in_valid_i (in_valid_i),
    .op_i       (op_i),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .in_ready_o (in_ready_o)
  );

  // datapath: link table, head, counters, divider, multiplier, output beat register
  fbfl_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .offset_i       (offset_i),
    .out_ready_i    (out_ready_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .out_valid_o    (out_valid_o),
    .status_o       (status_o),
    .block_offset_o (block_offset_o),
    .block_index_o  (block_index_o),
    .used_count_o   (used_count_o),
    .pool_empty_o   (pool_empty_o),
    .is_full_o      (is_full_o)
  );

endmodule

// ===== verif/fixed_block_free_list_unit_test.sv =====
module fixed_block_free_list_unit_test;
  import fbfl_pkg::*;

  // ---------------------------------------------------------------------------
  // Run shape
  // ---------------------------------------------------------------------------
  localparam int unsigned IDLE_MAX      = 16;   // per-beat gap / stall draw, 0..16
  localparam int unsigned SETTLE_CYCLES = 20;   // covers the free path through the divider, plus margin
  localparam int unsigned HOLD_AT       = 600;  // result beat that triggers the long stall
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned N_PHASES      = 12;
  localparam int unsigned PHASE_ITEMS   = 148;
  localparam int unsigned DIR_ROWS      = 30;

  // One result beat, field for field.
  typedef struct packed {
    fbfl_status_e       status;
    logic [OFF_W-1:0]   blk_off;
    logic [IDX_W-1:0]   blk_idx;
    logic [CNT_W-1:0]   used;
    logic               empty;
    logic               full;
  } alloc_res_t;

  typedef enum logic { ROW_BEAT, ROW_CFG } row_kind_e;
  // CHK_TYPED rows carry their own expected beat; CHK_PRED rows use the predictor.
  typedef enum logic { CHK_PRED, CHK_TYPED } chk_mode_e;

  typedef struct packed {
    row_kind_e          kind;
    logic [CFG_W-1:0]   cfg_val;
    logic               op;
    logic [OFF_W-1:0]   off;
    chk_mode_e          chk;
    alloc_res_t         want;
  } dir_row_t;

  localparam alloc_res_t NO_RES = '0;

  // Directed rows. Reset leaves the block size at 2, i.e. 4096 blocks.
  localparam dir_row_t DIR_TBL [DIR_ROWS] = '{
    // fresh list pops 0 then 1
    '{ROW_BEAT, 14'd0, OP_ALLOC, 13'd0, CHK_TYPED, '{ST_OK, 13'd0, 12'd0, 13'd1, 1'b0, 1'b0}},
    '{ROW_BEAT, 14'd0, OP_ALLOC, 13'd0, CHK_TYPED, '{ST_OK, 13'd2, 12'd1, 13'd2, 1'b0, 1'b0}},
    // odd offsets, top of range included
    '{ROW_BEAT, 14'd0, OP_FREE, 13'd8191, CHK_TYPED,
      '{ST_ALIGN, 13'd0, 12'd0, 13'd2, 1'b0, 1'b0}},
    '{ROW_BEAT, 14'd0, OP_FREE, 13'd1, CHK_TYPED, '{ST_ALIGN, 13'd0, 12'd0, 13'd2, 1'b0, 1'b0}},
    // last block, never handed out: pushed anyway
    '{ROW_BEAT, 14'd0, OP_FREE, 13'd8190, CHK_TYPED,
      '{ST_OK, 13'd8190, 12'd4095, 13'd1, 1'b0, 1'b0}},
    '{ROW_BEAT, 14'd0, OP_FREE, 13'd2, CHK_TYPED, '{ST_OK, 13'd2, 12'd1, 13'd0, 1'b1, 1'b0}},
    // double free with nothing in use, then pops off the self-linked head
    '{ROW_BEAT, 14'd0, OP_FREE, 13'd2, CHK_PRED, NO_RES},
    '{ROW_BEAT, 14'd0, OP_ALLOC, 13'd0, CHK_PRED, NO_RES},
    '{ROW_BEAT, 14'd0, OP_ALLOC, 13'd0, CHK_PRED, NO_RES},
    // size 3: 2730 blocks, 2 bytes of tail slack
    '{ROW_CFG, 14'd3, OP_ALLOC, 13'd0, CHK_PRED, NO_RES},
    '{ROW_BEAT, 14'd0, OP_FREE, 13'd8190, CHK_TYPED,
      '{ST_RANGE, 13'd0, 12'd0, 13'd0, 1'b1, 1'b0}},
    '{ROW_BEAT, 14'd0, OP_FREE, 13'd4, CHK_TYPED, '{ST_ALIGN, 13'd0, 12'd0, 13'd0, 1'b1, 1'b0}},
    '{ROW_BEAT, 14'd0, OP_ALLOC, 13'd8191, CHK_TYPED,
      '{ST_OK, 13'd0, 12'd0, 13'd1, 1'b0, 1'b0}},
    '{ROW_BEAT, 14'd0, OP_FREE, 13'd0, CHK_PRED, NO_RES},
    // one block covers the whole bucket
    '{ROW_CFG, 14'd8192, OP_ALLOC, 13'd0, CHK_PRED, NO_RES},
    '{ROW_BEAT, 14'd0, OP_ALLOC, 13'd0, CHK_TYPED, '{ST_OK, 13'd0, 12'd0, 13'd1, 1'b0, 1'b1}},
    '{ROW_BEAT, 14'd0, OP_ALLOC, 13'd0, CHK_TYPED, '{ST_FULL, 13'd0, 12'd0, 13'd1, 1'b0, 1'b1}},
    '{ROW_BEAT, 14'd0, OP_FREE, 13'd4096, CHK_TYPED,
      '{ST_ALIGN, 13'd0, 12'd0, 13'd1, 1'b0, 1'b1}},
    '{ROW_BEAT, 14'd0, OP_FREE, 13'd0, CHK_TYPED, '{ST_OK, 13'd0, 12'd0, 13'd0, 1'b1, 1'b0}},
    // block larger than bucket: zero blocks, empty and full at once
    '{ROW_CFG, 14'd16383, OP_ALLOC, 13'd0, CHK_PRED, NO_RES},
    '{ROW_BEAT, 14'd0, OP_ALLOC, 13'd0, CHK_TYPED, '{ST_FULL, 13'd0, 12'd0, 13'd0, 1'b1, 1'b1}},
    '{ROW_BEAT, 14'd0, OP_FREE, 13'd0, CHK_TYPED, '{ST_RANGE, 13'd0, 12'd0, 13'd0, 1'b1, 1'b1}},
    // sizes below 2 act as 2
    '{ROW_CFG, 14'd1, OP_ALLOC, 13'd0, CHK_PRED, NO_RES},
    '{ROW_BEAT, 14'd0, OP_FREE, 13'd1, CHK_TYPED, '{ST_ALIGN, 13'd0, 12'd0, 13'd0, 1'b1, 1'b0}},
    '{ROW_BEAT, 14'd0, OP_ALLOC, 13'd8191, CHK_TYPED,
      '{ST_OK, 13'd0, 12'd0, 13'd1, 1'b0, 1'b0}},
    '{ROW_BEAT, 14'd0, OP_ALLOC, 13'd0, CHK_PRED, NO_RES},
    '{ROW_CFG, 14'd0, OP_ALLOC, 13'd0, CHK_PRED, NO_RES},
    '{ROW_BEAT, 14'd0, OP_ALLOC, 13'd0, CHK_TYPED, '{ST_OK, 13'd0, 12'd0, 13'd1, 1'b0, 1'b0}},
    '{ROW_BEAT, 14'd0, OP_FREE, 13'd0, CHK_PRED, NO_RES},
    '{ROW_BEAT, 14'd0, OP_FREE, 13'd8191, CHK_PRED, NO_RES}
  };

  // Block sizes of the random phases; the last slot is drawn at run time.
  localparam logic [CFG_W-1:0] PHASE_SIZE [N_PHASES] = '{
    14'd64, 14'd1000, 14'd3, 14'd4096, 14'd100, 14'd2,
    14'd8192, 14'd16383, 14'd0, 14'd7, 14'd500, 14'd0
  };

  // ---------------------------------------------------------------------------
  // DUT hookup; every input starts at a known value
  // ---------------------------------------------------------------------------
  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               cfg_we    = 1'b0;
  logic [CFG_W-1:0]   cfg_wdata = '0;
  logic               in_valid  = 1'b0;
  logic               in_ready;
  logic               op        = OP_ALLOC;
  logic [OFF_W-1:0]   offset    = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [1:0]         status;
  logic [OFF_W-1:0]   blk_offset;
  logic [IDX_W-1:0]   blk_index;
  logic [CNT_W-1:0]   used_count;
  logic               pool_empty;
  logic               is_full;

  fixed_block_free_list_unit i_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .op_i           (op),
    .offset_i       (offset),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .status_o       (status),
    .block_offset_o (blk_offset),
    .block_index_o  (blk_index),
    .used_count_o   (used_count),
    .pool_empty_o   (pool_empty),
    .is_full_o      (is_full)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Free-list predictor: own copy of the link table and counters
  // ---------------------------------------------------------------------------
  logic [OFF_W-1:0]   link_tbl [MAX_BLOCKS];
  logic [OFF_W-1:0]   head_idx;
  logic [CNT_W-1:0]   used_cnt;
  logic [CNT_W-1:0]   blk_cnt;
  logic [CFG_W-1:0]   blk_size;

  alloc_res_t         pending_res [$];  // results owed by the DUT, oldest first
  int                 live_idx [$];     // blocks handed out, drives well-formed frees
  int unsigned        err_cnt   = 0;
  int unsigned        gap_max   = IDLE_MAX;
  int unsigned        stall_max = IDLE_MAX;

  function automatic int unsigned eff_size();
    return (blk_size < MIN_BLOCK) ? MIN_BLOCK : int'(blk_size);
  endfunction

  // Re-chain block i -> i+1 and recompute the block count (capped at MAX_BLOCKS).
  function automatic void rebuild_free_list(input logic [CFG_W-1:0] bsz);
    int unsigned n;
    int unsigned i;
    blk_size = bsz;
    n = BUCKET_BYTES / eff_size();
    if (n > MAX_BLOCKS) n = MAX_BLOCKS;
    blk_cnt = CNT_W'(n);
    for (i = 0; i < MAX_BLOCKS; i++) link_tbl[i] = OFF_W'(i + 1);
    head_idx = '0;
    used_cnt = '0;
  endfunction

  function automatic alloc_res_t step_free_list(input logic op_v, input logic [OFF_W-1:0] off_v);
    alloc_res_t  r;
    int unsigned bs;
    int unsigned ofs;
    int unsigned idx;
    r = '0;
    r.status = ST_OK;
    bs = eff_size();
    ofs = int'(off_v);
    if (op_v == OP_ALLOC) begin
      // a head past the block count (list broken by double frees) also reads as full
      if (used_cnt >= blk_cnt || int'(head_idx) >= int'(blk_cnt)) begin
        r.status = ST_FULL;
      end else begin
        r.blk_idx = IDX_W'(head_idx);
        r.blk_off = OFF_W'(int'(head_idx) * bs);
        head_idx  = link_tbl[head_idx];
        used_cnt  = used_cnt + 1'b1;
      end
    end else if (ofs >= BUCKET_BYTES) begin
      r.status = ST_RANGE;
    end else if (ofs % bs != 0) begin
      r.status = ST_ALIGN;
    end else begin
      idx = ofs / bs;
      if (idx >= int'(blk_cnt)) begin
        r.status = ST_RANGE;   // tail slack
      end else begin
        // push; double frees go through unchecked, used count floors at 0
        link_tbl[idx] = head_idx;
        head_idx      = OFF_W'(idx);
        if (used_cnt != 0) used_cnt = used_cnt - 1'b1;
        r.blk_idx = IDX_W'(idx);
        r.blk_off = off_v;
      end
    end
    r.used  = used_cnt;
    r.empty = (used_cnt == 0);
    r.full  = (used_cnt == blk_cnt);
    return r;
  endfunction

  function automatic void check_field(input string what, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
      err_cnt++;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------
  // Offer one beat after a random gap; valid stays up back to back when the gap is 0.
  task automatic send_item(input logic op_v, input logic [OFF_W-1:0] off_v,
                           input chk_mode_e mode, input alloc_res_t typed_res);
    int unsigned gap;
    alloc_res_t  res;
    int          hits [$];
    gap = $urandom_range(0, gap_max);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    op       <= op_v;
    offset   <= off_v;
    do @(posedge clk); while (!in_ready);
    res = step_free_list(op_v, off_v);
    pending_res.push_back((mode == CHK_TYPED) ? typed_res : res);
    if (res.status == ST_OK) begin
      if (op_v == OP_ALLOC) begin
        live_idx.push_back(int'(res.blk_idx));
      end else begin
        hits = live_idx.find_first_index(x) with (x == int'(res.blk_idx));
        if (hits.size() != 0) live_idx.delete(hits[0]);
      end
    end
  endtask

  // Stop offering and wait out every owed result, then let the datapath settle.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_res.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register writes only on an idle unit; the write restarts the link sweep.
  task automatic set_block_size(input logic [CFG_W-1:0] bsz);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= bsz;
    @(posedge clk);
    cfg_we    <= 1'b0;
    rebuild_free_list(bsz);
    live_idx.delete();
  endtask

  initial begin : stimulus
    int unsigned      row;
    int unsigned      p;
    int unsigned      i;
    int unsigned      roll;
    int unsigned      bs;
    int unsigned      alloc_pct;
    logic [CFG_W-1:0] bsz;
    logic             op_v;
    logic [OFF_W-1:0] off_v;

    rebuild_free_list(CFG_W'(CFG_RESET));
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    // first beat simply waits out the post-reset sweep on in_ready

    // directed table
    for (row = 0; row < DIR_ROWS; row++) begin
      if (DIR_TBL[row].kind == ROW_CFG) begin
        set_block_size(DIR_TBL[row].cfg_val);
      end else begin
        send_item(DIR_TBL[row].op, DIR_TBL[row].off, DIR_TBL[row].chk, DIR_TBL[row].want);
      end
    end

    // random phases: each one rewrites the block size and mixes idle patterns
    for (p = 0; p < N_PHASES; p++) begin
      bsz = (p == N_PHASES - 1) ? CFG_W'($urandom_range(MIN_BLOCK, BUCKET_BYTES))
                                : PHASE_SIZE[p];
      gap_max   = (p % 3 == 0) ? 0 : IDLE_MAX;
      stall_max = (p % 4 == 1) ? 0 : IDLE_MAX;
      alloc_pct = $urandom_range(35, 75);
      set_block_size(bsz);
      bs = eff_size();
      for (i = 0; i < PHASE_ITEMS; i++) begin
        // sender pause mid-phase until nothing is owed
        if (p == 5 && i == PHASE_ITEMS / 2) drain_results();
        roll = $urandom_range(0, 99);
        if (roll < 2 && blk_cnt != 0) begin
          // any aligned block, busy or not: double frees
          op_v  = OP_FREE;
          off_v = OFF_W'($urandom_range(0, int'(blk_cnt) - 1) * bs);
        end else if (roll < 6 && int'(blk_cnt) * bs < BUCKET_BYTES) begin
          // first offset past the last block
          op_v  = OP_FREE;
          off_v = OFF_W'(int'(blk_cnt) * bs);
        end else if (roll < 16) begin
          op_v  = logic'($urandom_range(0, 1));
          off_v = OFF_W'($urandom);
        end else if (live_idx.size() == 0 || $urandom_range(0, 99) < alloc_pct) begin
          op_v  = OP_ALLOC;
          off_v = OFF_W'($urandom);   // don't-care on allocate
        end else begin
          op_v  = OP_FREE;
          off_v = OFF_W'(live_idx[$urandom_range(0, live_idx.size() - 1)] * bs);
        end
        send_item(op_v, off_v, CHK_PRED, NO_RES);
      end
    end

    drain_results();
    if (err_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Receiver side: random stalls, one long hold-off so the input backs up
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int unsigned stall;
    int unsigned beats;
    alloc_res_t  want;
    beats = 0;
    wait (rst_n === 1'b1);
    forever begin
      stall = (beats == HOLD_AT) ? HOLD_CYCLES : $urandom_range(0, stall_max);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      beats++;
      if (pending_res.size() == 0) begin
        $display("%0t: result beat with no item outstanding, expected none, got status %0d",
                 $time, status);
        err_cnt++;
      end else begin
        want = pending_res.pop_front();
        check_field("status",       16'(want.status),  16'(status));
        check_field("block_offset", 16'(want.blk_off), 16'(blk_offset));
        check_field("block_index",  16'(want.blk_idx), 16'(blk_index));
        check_field("used_count",   16'(want.used),    16'(used_count));
        check_field("pool_empty",   16'(want.empty),   16'(pool_empty));
        check_field("is_full",      16'(want.full),    16'(is_full));
      end
    end
  end

  // Watchdog, several times the slowest legal run.
  initial begin : watchdog
    #8_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ===== fixed_block_free_list_unit.f =====
+incdir+hw/rtl
hw/rtl/fbfl_pkg.sv
hw/rtl/fbfl_div.sv
hw/rtl/fbfl_dp.sv
hw/rtl/fbfl_ctrl.sv
hw/rtl/fixed_block_free_list_unit.sv
verif/fixed_block_free_list_unit_test.sv
